[rtl/scr_pkg.sv]
// shared constants, cell state type and register indexes for the stepped cube root
package scr_pkg;

  localparam int IN_FRAC_BITS_DEF  = 16;
  localparam int IN_INT_BITS_DEF   = 24;
  localparam int OUT_FRAC_BITS_DEF = 24;

  localparam int ROOT_W      = 34;
  localparam int STEP_W      = 25;
  localparam int SEARCH_BITS = 42;
  localparam int TGT_W       = 3 * SEARCH_BITS;
  localparam int SQ_W        = 2 * SEARCH_BITS;
  localparam int REM_W       = 2 * SEARCH_BITS + 6;
  localparam int CNT_W       = $clog2(SEARCH_BITS + 1);
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_LARGE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_BAND    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SMALL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_DEFAULT = 3'd3;

  localparam logic [STEP_W-1:0] STEP_LARGE_RST   = 25'd1678;
  localparam logic [STEP_W-1:0] STEP_BAND_RST    = 25'd168;
  localparam logic [STEP_W-1:0] STEP_SMALL_RST   = 25'd17;
  localparam logic [STEP_W-1:0] STEP_DEFAULT_RST = 25'd16777;

  localparam logic [63:0] TIER_LARGE_LO = 64'd10000;
  localparam logic [63:0] TIER_LARGE_HI = 64'd999999;
  localparam logic [63:0] TIER_BAND_LO  = 64'd329;
  localparam logic [63:0] TIER_BAND_HI  = 64'd349;
  localparam logic [63:0] TIER_SMALL_HI = 64'd9999;

  typedef struct packed {
    logic                   valid;
    logic [SEARCH_BITS-1:0] y;
    logic [SQ_W-1:0]        s;
    logic [REM_W-1:0]       rem;
  } cell_t;

endpackage

[rtl/scr_cell.sv]
// one root bit of the digit-by-digit cube root, registered toward the next cell
module scr_cell import scr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [2:0]  tgt_bits,
  input  cell_t       cell_in,
  output cell_t       cell_out
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             take;
  cell_t            cell_r;
  cell_t            cell_nxt;

  always_comb begin
    rem_sh = {cell_in.rem[REM_W-4:0], tgt_bits};
    // (2y+1)^3 - 8y^3 = 12y^2 + 6y + 1
    trial  = (REM_W'(cell_in.s) << 3) + (REM_W'(cell_in.s) << 2)
           + (REM_W'(cell_in.y) << 2) + (REM_W'(cell_in.y) << 1) + REM_W'(1);
    take   = (rem_sh >= trial);
    cell_nxt.valid = cell_in.valid;
    cell_nxt.y     = {cell_in.y[SEARCH_BITS-2:0], take};
    cell_nxt.s     = take ? ((cell_in.s << 2) + (SQ_W'(cell_in.y) << 2) + SQ_W'(1))
                          : (cell_in.s << 2);
    cell_nxt.rem   = take ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    cell_r.y   <= cell_nxt.y;
    cell_r.s   <= cell_nxt.s;
    cell_r.rem <= cell_nxt.rem;
  end

  assign cell_out = cell_r;

endmodule

[rtl/scr_div.sv]
// bit-serial restoring remainder of the root by the grid step
module scr_div import scr_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [SEARCH_BITS-1:0] dividend,
  input  logic [STEP_W-1:0]      divisor,
  output logic                   done,
  output logic [STEP_W-1:0]      rem
);

  logic [SEARCH_BITS-1:0] dq_r;
  logic [STEP_W-1:0]      d_r;
  logic [STEP_W-1:0]      r_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   run_r;
  logic                   done_r;
  logic [STEP_W:0]        r_sh;
  logic [STEP_W-1:0]      r_nxt;

  always_comb begin
    r_sh  = {r_r, dq_r[SEARCH_BITS-1]};
    r_nxt = (r_sh >= {1'b0, d_r}) ? STEP_W'(r_sh - {1'b0, d_r}) : STEP_W'(r_sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(SEARCH_BITS);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r <= dividend;
      d_r  <= divisor;
      r_r  <= '0;
    end else if (run_r) begin
      dq_r <= dq_r << 1;
      r_r  <= r_nxt;
    end
  end

  assign done = done_r;
  assign rem  = r_r;

endmodule

[rtl/stepped_cube_root.sv]
// top level of the stepped cube root: step registers, control, cell chain and remainder unit
//
// A request is taken when start is high and busy is low; busy stays high until the result
// strobe. A nonzero operand is launched into the chain, walks the 42-cell chain one root
// bit per cell, is handed to the serial remainder unit, which loads it and snaps the root
// onto the step grid bit by bit, and the result is then registered onto out_valid. A zero
// operand returns in the next cycle. Results are strobed for one cycle on out_valid and
// must be taken then; busy is already low in that cycle, so a new request may enter there.
// Step registers may be written whenever busy is low.
module stepped_cube_root import scr_pkg::*; #(
  parameter int IN_FRAC_BITS  = IN_FRAC_BITS_DEF,
  parameter int IN_INT_BITS   = IN_INT_BITS_DEF,
  parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [IN_INT_BITS+IN_FRAC_BITS-1:0] in_value_in,
  output logic                                 out_valid,
  output logic signed [ROOT_W-1:0]             out_root_out,
  output logic                                 out_exact_root,
  output logic                                 out_zero_input,
  input  logic                                 cfg_we,
  input  logic [CFG_IDX_W-1:0]                 cfg_index,
  input  logic [STEP_W-1:0]                    cfg_data
);

  localparam int IN_W      = IN_INT_BITS + IN_FRAC_BITS;
  localparam int TGT_SHIFT = 3 * OUT_FRAC_BITS - IN_FRAC_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROOT = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [STEP_W-1:0] step_large_r, step_band_r, step_small_r, step_default_r;
  logic [1:0]        state_r;
  logic              go_r;
  logic              div_go_r;
  logic              neg_r;
  logic              frac_zero_r;
  logic              exact_r;
  logic [TGT_W-1:0]  target_r;
  logic [STEP_W-1:0] step_r;
  logic [SEARCH_BITS-1:0] q_r;
  logic              out_valid_r;
  logic [ROOT_W-1:0] root_r;
  logic              exact_out_r;
  logic              zero_out_r;

  logic              accept;
  logic              neg;
  logic [IN_W-1:0]   mag;
  logic [63:0]       mag64;
  logic [STEP_W-1:0] step_sel;
  logic [STEP_W-1:0] step_nxt;
  logic              div_done;
  logic [STEP_W-1:0] div_rem;
  logic [SEARCH_BITS-1:0] root_mag;
  logic [ROOT_W-1:0] root_nxt;

  cell_t chain [0:SEARCH_BITS];

  assign accept = start && !busy;
  assign neg    = in_value_in[IN_W-1];
  assign mag    = neg ? (~in_value_in + IN_W'(1)) : in_value_in;
  assign mag64  = 64'(mag);

  always_comb begin
    if (mag64 > (TIER_LARGE_LO << IN_FRAC_BITS) && mag64 <= (TIER_LARGE_HI << IN_FRAC_BITS)) begin
      step_sel = step_large_r;
    end else if (mag64 > (TIER_BAND_LO << IN_FRAC_BITS)
                 && mag64 <= (TIER_BAND_HI << IN_FRAC_BITS)) begin
      step_sel = step_band_r;
    end else if (mag64 < (TIER_SMALL_HI << IN_FRAC_BITS)) begin
      step_sel = step_small_r;
    end else begin
      step_sel = step_default_r;
    end
    // a zero step behaves as one
    step_nxt = (step_sel == '0) ? STEP_W'(1) : step_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_large_r   <= STEP_LARGE_RST;
      step_band_r    <= STEP_BAND_RST;
      step_small_r   <= STEP_SMALL_RST;
      step_default_r <= STEP_DEFAULT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_LARGE:   step_large_r   <= cfg_data;
        REG_STEP_BAND:    step_band_r    <= cfg_data;
        REG_STEP_SMALL:   step_small_r   <= cfg_data;
        REG_STEP_DEFAULT: step_default_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // cell chain, one root bit per cell, three target bits consumed per cell
  assign chain[0].valid = go_r;
  assign chain[0].y     = '0;
  assign chain[0].s     = '0;
  assign chain[0].rem   = '0;

  genvar gi;
  generate
    for (gi = 0; gi < SEARCH_BITS; gi++) begin : g_cell
      scr_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .tgt_bits (target_r[TGT_W-1-3*gi -: 3]),
        .cell_in  (chain[gi]),
        .cell_out (chain[gi+1])
      );
    end
  endgenerate

  scr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (q_r),
    .divisor  (step_r),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    root_mag = exact_r ? q_r : (q_r - SEARCH_BITS'(div_rem));
    root_nxt = neg_r ? (~ROOT_W'(root_mag) + ROOT_W'(1)) : ROOT_W'(root_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      go_r        <= 1'b0;
      div_go_r    <= 1'b0;
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (mag == '0) begin
              out_valid_r <= 1'b1;
            end else begin
              go_r    <= 1'b1;
              state_r <= ST_ROOT;
            end
          end
        end
        ST_ROOT: begin
          if (chain[SEARCH_BITS].valid) begin
            div_go_r <= 1'b1;
            state_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r       <= neg;
      frac_zero_r <= (mag[IN_FRAC_BITS-1:0] == '0);
      target_r    <= TGT_W'(mag) << TGT_SHIFT;
      step_r      <= step_nxt;
      root_r      <= '0;
      exact_out_r <= 1'b0;
      zero_out_r  <= (mag == '0);
    end else if (state_r == ST_ROOT && chain[SEARCH_BITS].valid) begin
      q_r     <= chain[SEARCH_BITS].y;
      // integer operand whose scaled cube root leaves nothing over is a perfect cube
      exact_r <= frac_zero_r && (chain[SEARCH_BITS].rem == '0);
    end else if (state_r == ST_DIV && div_done) begin
      root_r      <= root_nxt;
      exact_out_r <= exact_r;
      zero_out_r  <= 1'b0;
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_root_out   = root_r;
  assign out_exact_root = exact_out_r;
  assign out_zero_input = zero_out_r;

endmodule

[rtl/scr_chk.sv]
// port-level checks on the stepped cube root, bound to the top level
module scr_chk import scr_pkg::*; #(
  parameter int IN_W = IN_INT_BITS_DEF + IN_FRAC_BITS_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic signed [IN_W-1:0]   in_value_in,
  input logic                     out_valid,
  input logic signed [ROOT_W-1:0] out_root_out,
  input logic                     out_exact_root,
  input logic                     out_zero_input
);

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_exact_root && out_zero_input))
    else $error("exact and zero flags together");

  a_zero_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_input |-> out_root_out == '0)
    else $error("zero request gave nonzero root");

  a_zero_fast: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_value_in == '0 |=> out_valid && out_zero_input && !busy)
    else $error("zero request not answered next cycle");

  a_busy_on: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_value_in != '0 |=> busy && !out_valid)
    else $error("nonzero request did not raise busy");

  a_strobe_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_zero_input |-> !busy && $past(busy))
    else $error("result strobe without finishing request");

endmodule

bind stepped_cube_root scr_chk #(.IN_W(IN_INT_BITS + IN_FRAC_BITS)) u_scr_chk (.*);

[bench/tb.sv]
// self-checking testbench for the stepped cube root
`timescale 1ns / 100ps

module tb;
  import scr_pkg::*;

  localparam int IN_W = IN_INT_BITS_DEF + IN_FRAC_BITS_DEF;
  localparam int TGT_SHIFT = 3 * OUT_FRAC_BITS_DEF - IN_FRAC_BITS_DEF;
  localparam longint ONE = 64'd1 << IN_FRAC_BITS_DEF;

  typedef struct {
    logic [ROOT_W-1:0] root;
    bit                exact;
    bit                zero;
  } root_res_t;

  typedef struct {
    logic [IN_W-1:0]   value;
    bit                known;
    logic [ROOT_W-1:0] root;
    bit                exact;
    bit                zero;
  } dir_row_t;

  logic                    clk;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [IN_W-1:0]  in_value_in;
  logic                    out_valid;
  logic signed [ROOT_W-1:0] out_root_out;
  logic                    out_exact_root;
  logic                    out_zero_input;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [STEP_W-1:0]       cfg_data;

  // copy of the step registers
  logic [STEP_W-1:0] stp_large, stp_band, stp_small, stp_default;
  root_res_t root_q[$];
  int mismatches;
  int idle_pct;

  dir_row_t dir_rows[] = '{
    '{40'd0, 1, 34'd0, 0, 1},
    '{40'd1 << 16, 1, 34'd1 << 24, 1, 0},
    '{-(40'd1 << 16), 1, -(34'd1 << 24), 1, 0},
    '{40'd8 << 16, 1, 34'd2 << 24, 1, 0},
    '{-(40'd27 << 16), 1, -(34'd3 << 24), 1, 0},
    '{40'd8000000 << 16, 1, 34'd200 << 24, 1, 0},
    '{40'h7f_ffff_ffff, 0, 0, 0, 0},
    '{40'h80_0000_0000, 0, 0, 0, 0},
    '{40'd1, 0, 0, 0, 0},
    '{40'hff_ffff_ffff, 0, 0, 0, 0},
    '{40'd2 << 16, 0, 0, 0, 0},
    '{(40'd10000 << 16), 0, 0, 0, 0},
    '{(40'd10000 << 16) + 1, 0, 0, 0, 0},
    '{(40'd999999 << 16), 0, 0, 0, 0},
    '{(40'd999999 << 16) + 1, 0, 0, 0, 0},
    '{(40'd329 << 16), 0, 0, 0, 0},
    '{(40'd329 << 16) + 1, 0, 0, 0, 0},
    '{-(40'd349 << 16), 0, 0, 0, 0},
    '{(40'd349 << 16) + 1, 0, 0, 0, 0},
    '{(40'd9999 << 16) - 1, 0, 0, 0, 0},
    '{(40'd9999 << 16), 0, 0, 0, 0},
    '{-(40'd5000 << 16) - 7, 0, 0, 0, 0}
  };

  stepped_cube_root i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_value_in(in_value_in),
    .out_valid(out_valid), .out_root_out(out_root_out), .out_exact_root(out_exact_root),
    .out_zero_input(out_zero_input), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40000000;
    $display("FAIL");
    $finish;
  end

  // largest q below 2^42 whose cube does not exceed t
  function automatic logic [63:0] floor_cbrt(input logic [127:0] t);
    logic [63:0] q;
    logic [127:0] c;
    q = 0;
    for (int b = SEARCH_BITS - 1; b >= 0; b--) begin
      c = {64'd0, q | (64'd1 << b)};
      if (c * c * c <= t) q = c[63:0];
    end
    return q;
  endfunction

  function automatic root_res_t stepped_root(input logic [IN_W-1:0] v);
    root_res_t r;
    logic [63:0] mag, n, k, stp, q, root;
    bit neg;
    neg = v[IN_W-1];
    mag = neg ? (64'd1 << IN_W) - {24'd0, v} : {24'd0, v};
    r = '{0, 0, 0};
    if (mag == 0) begin
      r.zero = 1;
      return r;
    end
    root = 0;
    if (mag[IN_FRAC_BITS_DEF-1:0] == 0) begin
      n = mag >> IN_FRAC_BITS_DEF;
      k = floor_cbrt({64'd0, n});
      if (k * k * k == n) begin
        r.exact = 1;
        root = k << OUT_FRAC_BITS_DEF;
      end
    end
    if (!r.exact) begin
      if (mag > 10000 * ONE && mag <= 999999 * ONE) stp = 64'(stp_large);
      else if (mag > 329 * ONE && mag <= 349 * ONE) stp = 64'(stp_band);
      else if (mag < 9999 * ONE) stp = 64'(stp_small);
      else stp = 64'(stp_default);
      if (stp == 0) stp = 1;
      q = floor_cbrt({64'd0, mag} << TGT_SHIFT);
      root = (q / stp) * stp;
    end
    if (neg) root = ~root + 1;
    r.root = root[ROOT_W-1:0];
    return r;
  endfunction

  // the caller drops cfg_we after its last write
  task automatic write_step(input logic [CFG_IDX_W-1:0] idx, input logic [STEP_W-1:0] d);
    cfg_index <= idx;
    cfg_data  <= d;
    cfg_we    <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_STEP_LARGE:   stp_large = d;
      REG_STEP_BAND:    stp_band = d;
      REG_STEP_SMALL:   stp_small = d;
      REG_STEP_DEFAULT: stp_default = d;
      default: ;
    endcase
  endtask

  // wait out all pending results, then idle for config writes
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (root_q.size() != 0) @(posedge clk);
  endtask

  task automatic send_request(input logic [IN_W-1:0] v, input bit known, input root_res_t res);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_value_in <= v;
    do @(posedge clk); while (busy);
    root_q.push_back(known ? res : stepped_root(v));
  endtask

  function automatic logic [IN_W-1:0] rand_operand();
    logic [IN_W-1:0] v;
    logic [63:0] k;
    case ($urandom_range(9))
      0: v = IN_W'({$urandom, $urandom});
      1: v = IN_W'($urandom_range(255));
      2: v = 0;
      3: begin
        k = 64'($urandom_range(203));
        v = IN_W'((k * k * k) << IN_FRAC_BITS_DEF);
      end
      4: v = IN_W'((64'd329 * ONE) + 64'($urandom_range(21 * 65536)));
      5: v = IN_W'((64'd10000 * ONE) + 64'({$urandom_range(989999), 16'(($urandom))}));
      6: v = IN_W'((64'd9990 * ONE) + 64'($urandom_range(20 * 65536)));
      7: v = IN_W'({$urandom_range(8191), 16'($urandom)});
      default: v = IN_W'({$urandom, $urandom} >> $urandom_range(39));
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  always @(posedge clk) begin
    root_res_t e;
    if (rst_n && out_valid) begin
      if (root_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result root=%h", out_root_out);
      end else begin
        e = root_q.pop_front();
        if (out_root_out !== e.root || out_exact_root !== e.exact
            || out_zero_input !== e.zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp root=%h exact=%b zero=%b, got root=%h exact=%b zero=%b",
                     e.root, e.exact, e.zero, out_root_out, out_exact_root, out_zero_input);
        end
      end
    end
  end

  initial begin
    logic [STEP_W-1:0] cfg_sets[6][4];
    root_res_t res;
    int total;
    mismatches = 0;
    idle_pct = 29;
    rst_n = 1'b0;
    start = 1'b0;
    in_value_in = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    stp_large = STEP_LARGE_RST;
    stp_band = STEP_BAND_RST;
    stp_small = STEP_SMALL_RST;
    stp_default = STEP_DEFAULT_RST;
    cfg_sets = '{
      '{STEP_LARGE_RST, STEP_BAND_RST, STEP_SMALL_RST, STEP_DEFAULT_RST},
      '{25'd1, 25'd1, 25'd1, 25'd1},
      '{25'd0, 25'd0, 25'd0, 25'd0},
      '{25'h1ff_ffff, 25'h1ff_ffff, 25'h1ff_ffff, 25'h1ff_ffff},
      '{25'h100_0000, 25'd3, 25'd100000, 25'd7},
      '{25'd0, 25'd0, 25'd0, 25'd0}
    };
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      res = '{dir_rows[i].root, dir_rows[i].exact, dir_rows[i].zero};
      send_request(dir_rows[i].value, dir_rows[i].known, res);
    end

    total = 0;
    for (int p = 0; p < 6; p++) begin
      drain();
      if (p == 5) begin
        for (int r = 0; r < 4; r++) cfg_sets[5][r] = STEP_W'($urandom_range(1, 2000));
      end
      for (int r = 0; r < 4; r++) write_step(CFG_IDX_W'(r), cfg_sets[p][r]);
      // writes to unused indexes must not disturb the steps
      write_step(CFG_IDX_W'($urandom_range(4, 7)), STEP_W'($urandom));
      cfg_we <= 1'b0;
      for (int i = 0; i < 155; i++) begin
        idle_pct = (total < 310) ? 29 : (total < 620) ? 70 : 0;
        if (total % 97 > 80) idle_pct = 0;
        res = '{0, 0, 0};
        send_request(rand_operand(), 0, res);
        total++;
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && root_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/scr_pkg.sv
rtl/scr_cell.sv
rtl/scr_div.sv
rtl/stepped_cube_root.sv
rtl/scr_chk.sv
bench/tb.sv
